>>> rtl/core/ncs_pkg.sv
// Shared types, constants and saturation helpers for the natural cubic
// spline coefficient solver. No dependencies.
package ncs_pkg;

  localparam int DEF_MAX_KNOTS = 64;
  localparam int DEF_FRAC_BITS = 16;
  localparam int ADDR_MAX_W    = 10;
  localparam int IDX_W         = 6;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [65:0] SAT_HI  = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_LO  = -66'sh0_8000_0000;
  // floor(v * RECIP3 / 2^33) == floor(v / 3) for v < 2^32
  localparam logic signed [32:0] RECIP3  = 33'sh0_AAAA_AAAB;

  typedef struct packed {
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;
    logic               last_knot;
  } knot_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] segment_start;
    logic [IDX_W-1:0]   segment_index;
    logic               final_segment;
    logic               overflow_flag;
  } segment_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_SHIFT_F, OP_H, OP_DIV_S, OP_SC, OP_INIT, OP_MUL_MU,
    OP_L, OP_DIV_MU, OP_MUP, OP_MUL_Z, OP_TZ, OP_DIV_Z, OP_ZP, OP_WR_MZ,
    OP_LATCH_MZ, OP_SHIFT_B, OP_MUL_C, OP_C, OP_CS, OP_MUL_HC, OP_QH,
    OP_M3A, OP_D3A, OP_M3B, OP_D3B, OP_DIV_SL, OP_B, OP_DIV_D, OP_D,
    OP_WR_BCD, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic [ADDR_MAX_W-1:0] addr;
    logic                  last_seg;
    logic                  set_err;
    logic                  clr_err;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic signed [65:0] sx(input logic signed [31:0] a);
    return $signed({{34{a[31]}}, a});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > SAT_HI) return S32_MAX;
    if (v < SAT_LO) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > SAT_HI) || (v < SAT_LO);
  endfunction

endpackage

>>> rtl/core/ncs_div.sv
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// Depends on ncs_pkg.
module ncs_div #(
  parameter int FRAC_BITS = ncs_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] q,
  output logic               ovf
);
  localparam int QW = 32 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [QW-1:0] num_sh;
  logic [QW-1:0] quo;
  logic [32:0]   rem;
  logic [31:0]   den_mag;
  logic          neg;

  logic [32:0]   rem_try;
  logic          qbit;
  logic [QW-1:0] quo_fin;
  logic [31:0]   num_mag;

  always_comb begin
    rem_try = {rem[31:0], num_sh[QW-1]};
    qbit    = rem_try >= {1'b0, den_mag};
    quo_fin = {quo[QW-2:0], qbit};
    num_mag = num[31] ? 32'(-num) : 32'(num);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 32'sd0) begin
          q    <= num[31] ? ncs_pkg::S32_MIN : ncs_pkg::S32_MAX;
          ovf  <= 1'b1;
          done <= 1'b1;
        end else begin
          num_sh  <= {num_mag, {FRAC_BITS{1'b0}}};
          den_mag <= den[31] ? 32'(-den) : 32'(den);
          neg     <= num[31] ^ den[31];
          rem     <= '0;
          quo     <= '0;
          cnt     <= CW'(QW);
          running <= 1'b1;
        end
      end else if (running) begin
        rem    <= qbit ? (rem_try - {1'b0, den_mag}) : rem_try;
        quo    <= quo_fin;
        num_sh <= {num_sh[QW-2:0], 1'b0};
        cnt    <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
          if (!neg) begin
            ovf <= quo_fin > QW'(33'h0_7FFF_FFFF);
            q   <= (quo_fin > QW'(33'h0_7FFF_FFFF)) ? ncs_pkg::S32_MAX : quo_fin[31:0];
          end else begin
            ovf <= quo_fin > QW'(33'h0_8000_0000);
            q   <= (quo_fin > QW'(33'h0_8000_0000)) ? ncs_pkg::S32_MIN :
                   32'(-quo_fin[31:0]);
          end
        end
      end
    end
  end
endmodule

>>> rtl/core/ncs_datapath.sv
// Datapath: knot and sweep memories, work registers, shared multiplier,
// divider and result register. Depends on ncs_pkg and ncs_div.
module ncs_datapath #(
  parameter int MAX_KNOTS = ncs_pkg::DEF_MAX_KNOTS,
  parameter int FRAC_BITS = ncs_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  ncs_pkg::cmd_t     cmd,
  input  ncs_pkg::knot_t    knot,
  output ncs_pkg::status_t  status,
  output ncs_pkg::segment_t result,
  output logic              result_strobe
);
  localparam int AW = $clog2(MAX_KNOTS);

  logic signed [31:0] x_mem  [MAX_KNOTS];
  logic signed [31:0] y_mem  [MAX_KNOTS];
  logic signed [31:0] mu_mem [MAX_KNOTS];
  logic signed [31:0] z_mem  [MAX_KNOTS];
  logic signed [31:0] b_mem  [MAX_KNOTS];
  logic signed [31:0] c_mem  [MAX_KNOTS];
  logic signed [31:0] d_mem  [MAX_KNOTS];

  logic signed [31:0] x_rd, y_rd, mu_rd, z_rd, b_rd, c_rd, d_rd;
  logic [AW-1:0]      addr;

  logic signed [31:0] xa, xb, xc, yb, yc, hp, hc, sp, sc, mup, zp;
  logic signed [31:0] spn, alpha, lreg, treg, mur, zr, cn, cc, cs, dd;
  logic signed [31:0] qh, b3, d3, bb, dreg;
  logic signed [32:0] span;
  logic signed [65:0] prod;
  logic               psign;
  logic               err;

  logic               div_start, div_done, div_ovf;
  logic signed [31:0] div_num, div_den, div_q;

  logic signed [65:0] qm_w, h_w, y3_w, ydf_w, alpha_w, l_w, tz_w, c_w;
  logic signed [65:0] cs_w, dd_w, b_w;
  logic signed [31:0] qm_v, d3_mag, d3_v;
  logic signed [32:0] qh_abs, dd_abs;
  logic               e;

  assign addr = cmd.addr[AW-1:0];
  assign status.div_done = div_done;

  always_comb begin
    qm_w    = prod >>> FRAC_BITS;
    qm_v    = ncs_pkg::sat32(qm_w);
    h_w     = ncs_pkg::sx(xc) - ncs_pkg::sx(xb);
    ydf_w   = ncs_pkg::sx(yc) - ncs_pkg::sx(yb);
    y3_w    = (ydf_w <<< 1) + ydf_w;
    alpha_w = ncs_pkg::sx(sc) - ncs_pkg::sx(sp);
    l_w     = (ncs_pkg::sx(spn) <<< 1) - ncs_pkg::sx(qm_v);
    tz_w    = ncs_pkg::sx(alpha) - ncs_pkg::sx(qm_v);
    c_w     = ncs_pkg::sx(zr) - ncs_pkg::sx(qm_v);
    cs_w    = ncs_pkg::sx(cn) + (ncs_pkg::sx(cc) <<< 1);
    dd_w    = ncs_pkg::sx(cn) - ncs_pkg::sx(cc);
    b_w     = ncs_pkg::sx(div_q) - ncs_pkg::sx(b3);
    qh_abs  = qh[31] ? -{qh[31], qh} : {qh[31], qh};
    dd_abs  = dd[31] ? -{dd[31], dd} : {dd[31], dd};
    d3_mag  = {1'b0, prod[63:33]};
    d3_v    = psign ? -d3_mag : d3_mag;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = treg;
    div_den   = hc;
    unique case (cmd.op)
      ncs_pkg::OP_DIV_S:  div_start = 1'b1;
      ncs_pkg::OP_DIV_SL: div_start = 1'b1;
      ncs_pkg::OP_DIV_MU: begin
        div_start = 1'b1;
        div_num   = hc;
        div_den   = lreg;
      end
      ncs_pkg::OP_DIV_Z: begin
        div_start = 1'b1;
        div_den   = lreg;
      end
      ncs_pkg::OP_DIV_D: begin
        div_start = 1'b1;
        div_num   = d3;
      end
      default: ;
    endcase
  end

  always_comb begin
    e = 1'b0;
    unique case (cmd.op)
      ncs_pkg::OP_H:      e = ncs_pkg::ovf32(h_w) | ncs_pkg::ovf32(y3_w);
      ncs_pkg::OP_MUL_MU: e = ncs_pkg::ovf32(alpha_w) |
                              ncs_pkg::ovf32(66'(span));
      ncs_pkg::OP_L:      e = ncs_pkg::ovf32(qm_w) | ncs_pkg::ovf32(l_w);
      ncs_pkg::OP_TZ:     e = ncs_pkg::ovf32(qm_w) | ncs_pkg::ovf32(tz_w);
      ncs_pkg::OP_C:      e = ncs_pkg::ovf32(qm_w) | ncs_pkg::ovf32(c_w) |
                              ncs_pkg::ovf32(h_w) | ncs_pkg::ovf32(ydf_w);
      ncs_pkg::OP_CS:     e = ncs_pkg::ovf32(cs_w) | ncs_pkg::ovf32(dd_w);
      ncs_pkg::OP_QH:     e = ncs_pkg::ovf32(qm_w);
      ncs_pkg::OP_B:      e = div_ovf | ncs_pkg::ovf32(b_w);
      ncs_pkg::OP_SC, ncs_pkg::OP_MUP, ncs_pkg::OP_ZP, ncs_pkg::OP_D: e = div_ovf;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    x_rd  <= x_mem[addr];
    y_rd  <= y_mem[addr];
    mu_rd <= mu_mem[addr];
    z_rd  <= z_mem[addr];
    b_rd  <= b_mem[addr];
    c_rd  <= c_mem[addr];
    d_rd  <= d_mem[addr];
    if (cmd.op == ncs_pkg::OP_LOAD) begin
      x_mem[addr] <= knot.knot_x;
      y_mem[addr] <= knot.knot_y;
    end
    if (cmd.op == ncs_pkg::OP_WR_MZ) begin
      mu_mem[addr] <= mup;
      z_mem[addr]  <= zp;
    end
    if (cmd.op == ncs_pkg::OP_WR_BCD) begin
      b_mem[addr] <= bb;
      c_mem[addr] <= cc;
      d_mem[addr] <= dreg;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ncs_pkg::OP_SHIFT_F: begin
        xa <= xb;
        xb <= xc;
        xc <= x_rd;
        yb <= yc;
        yc <= y_rd;
        hp <= hc;
        sp <= sc;
      end
      ncs_pkg::OP_H: begin
        hc   <= ncs_pkg::sat32(h_w);
        treg <= ncs_pkg::sat32(y3_w);
        span <= {xc[31], xc} - {xa[31], xa};
      end
      ncs_pkg::OP_SC: sc <= div_q;
      ncs_pkg::OP_INIT: begin
        mup <= '0;
        zp  <= '0;
        cn  <= '0;
      end
      ncs_pkg::OP_MUL_MU: begin
        prod  <= ncs_pkg::sx(hp) * ncs_pkg::sx(mup);
        alpha <= ncs_pkg::sat32(alpha_w);
        spn   <= ncs_pkg::sat32(66'(span));
      end
      ncs_pkg::OP_L:    lreg <= ncs_pkg::sat32(l_w);
      ncs_pkg::OP_MUP:  mup <= div_q;
      ncs_pkg::OP_MUL_Z: prod <= ncs_pkg::sx(hp) * ncs_pkg::sx(zp);
      ncs_pkg::OP_TZ:   treg <= ncs_pkg::sat32(tz_w);
      ncs_pkg::OP_ZP:   zp <= div_q;
      ncs_pkg::OP_LATCH_MZ: begin
        mur <= mu_rd;
        zr  <= z_rd;
      end
      ncs_pkg::OP_SHIFT_B: begin
        mur <= mu_rd;
        zr  <= z_rd;
        xc  <= xb;
        xb  <= x_rd;
        yc  <= yb;
        yb  <= y_rd;
      end
      ncs_pkg::OP_MUL_C: prod <= ncs_pkg::sx(mur) * ncs_pkg::sx(cn);
      ncs_pkg::OP_C: begin
        cc   <= ncs_pkg::sat32(c_w);
        hc   <= ncs_pkg::sat32(h_w);
        treg <= ncs_pkg::sat32(ydf_w);
      end
      ncs_pkg::OP_CS: begin
        cs <= ncs_pkg::sat32(cs_w);
        dd <= ncs_pkg::sat32(dd_w);
      end
      ncs_pkg::OP_MUL_HC: prod <= ncs_pkg::sx(hc) * ncs_pkg::sx(cs);
      ncs_pkg::OP_QH:  qh <= qm_v;
      ncs_pkg::OP_M3A: begin
        prod  <= qh_abs * ncs_pkg::RECIP3;
        psign <= qh[31];
      end
      ncs_pkg::OP_D3A: b3 <= d3_v;
      ncs_pkg::OP_M3B: begin
        prod  <= dd_abs * ncs_pkg::RECIP3;
        psign <= dd[31];
      end
      ncs_pkg::OP_D3B: d3 <= d3_v;
      ncs_pkg::OP_B:   bb <= ncs_pkg::sat32(b_w);
      ncs_pkg::OP_D:   dreg <= div_q;
      ncs_pkg::OP_WR_BCD: cn <= cc;
      ncs_pkg::OP_EMIT: begin
        result.coef_a        <= y_rd;
        result.coef_b        <= b_rd;
        result.coef_c        <= c_rd;
        result.coef_d        <= d_rd;
        result.segment_start <= x_rd;
        result.segment_index <= ncs_pkg::IDX_W'(cmd.addr);
        result.final_segment <= cmd.last_seg;
        result.overflow_flag <= err;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err           <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.op == ncs_pkg::OP_EMIT;
      if (cmd.clr_err) begin
        err <= 1'b0;
      end else begin
        err <= err | e | cmd.set_err;
      end
    end
  end

  ncs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q),
    .ovf   (div_ovf)
  );
endmodule

>>> rtl/core/ncs_ctrl.sv
// Controller: knot counting, forward sweep, back substitution and emit
// sequencing. Depends on ncs_pkg.
module ncs_ctrl #(
  parameter int MAX_KNOTS = ncs_pkg::DEF_MAX_KNOTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last_knot,
  input  ncs_pkg::status_t status,
  output logic             busy,
  output ncs_pkg::cmd_t    cmd
);
  localparam int AW = $clog2(MAX_KNOTS);
  localparam int SN = 37;

  typedef enum logic [SN-1:0] {
    ST_IDLE  = SN'(1) << 0,  ST_F_R0  = SN'(1) << 1,  ST_F_SH0 = SN'(1) << 2,
    ST_F_SH  = SN'(1) << 3,  ST_F_H   = SN'(1) << 4,  ST_F_DS  = SN'(1) << 5,
    ST_F_SC  = SN'(1) << 6,  ST_F_INI = SN'(1) << 7,  ST_F_MM  = SN'(1) << 8,
    ST_F_L   = SN'(1) << 9,  ST_F_DM  = SN'(1) << 10, ST_F_MUP = SN'(1) << 11,
    ST_F_MZ  = SN'(1) << 12, ST_F_TZ  = SN'(1) << 13, ST_F_DZ  = SN'(1) << 14,
    ST_F_ZP  = SN'(1) << 15, ST_F_WR  = SN'(1) << 16, ST_F_RD  = SN'(1) << 17,
    ST_DW    = SN'(1) << 18, ST_B_RD  = SN'(1) << 19, ST_B_LAT = SN'(1) << 20,
    ST_B_MC  = SN'(1) << 21, ST_B_C   = SN'(1) << 22, ST_B_CS  = SN'(1) << 23,
    ST_B_MH  = SN'(1) << 24, ST_B_QH  = SN'(1) << 25, ST_B_M3A = SN'(1) << 26,
    ST_B_D3A = SN'(1) << 27, ST_B_M3B = SN'(1) << 28, ST_B_D3B = SN'(1) << 29,
    ST_B_DSL = SN'(1) << 30, ST_B_B   = SN'(1) << 31, ST_B_DD  = SN'(1) << 32,
    ST_B_D   = SN'(1) << 33, ST_B_WR  = SN'(1) << 34, ST_E_RD  = SN'(1) << 35,
    ST_E_OUT = SN'(1) << 36
  } state_t;

  state_t      state, state_next, ret, ret_next;
  logic [AW:0] cnt, cnt_next, cnt_eff;
  logic [AW-1:0] i, i_next, n_last;
  logic        first, first_next, init, init_next;

  assign busy    = state != ST_IDLE;
  assign n_last  = AW'(cnt - (AW+1)'(2));
  assign cnt_eff = (cnt < (AW+1)'(MAX_KNOTS)) ? cnt + (AW+1)'(1) : cnt;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cnt_next   = cnt;
    i_next     = i;
    first_next = first;
    init_next  = init;
    cmd        = '0;
    cmd.op     = ncs_pkg::OP_NONE;
    unique case (state)
      ST_IDLE: begin
        cmd.addr = ncs_pkg::ADDR_MAX_W'(cnt);
        if (start) begin
          if (cnt < (AW+1)'(MAX_KNOTS)) begin
            cmd.op = ncs_pkg::OP_LOAD;
          end else begin
            cmd.set_err = 1'b1;
          end
          cnt_next = cnt_eff;
          if (last_knot) begin
            if (cnt_eff < (AW+1)'(2)) begin
              cnt_next    = '0;
              cmd.clr_err = 1'b1;
            end else begin
              init_next  = 1'b1;
              state_next = ST_F_R0;
            end
          end
        end
      end
      ST_F_R0: state_next = ST_F_SH0;
      ST_F_SH0: begin
        cmd.op     = ncs_pkg::OP_SHIFT_F;
        cmd.addr   = ncs_pkg::ADDR_MAX_W'(1);
        state_next = ST_F_SH;
      end
      ST_F_SH: begin
        cmd.op     = ncs_pkg::OP_SHIFT_F;
        // two knots: no interior slope is formed
        state_next = (init && n_last == '0) ? ST_F_INI : ST_F_H;
      end
      ST_F_H: begin
        cmd.op     = ncs_pkg::OP_H;
        state_next = ST_F_DS;
      end
      ST_F_DS: begin
        cmd.op     = ncs_pkg::OP_DIV_S;
        ret_next   = ST_F_SC;
        state_next = ST_DW;
      end
      ST_DW: if (status.div_done) state_next = ret;
      ST_F_SC: begin
        cmd.op     = ncs_pkg::OP_SC;
        state_next = init ? ST_F_INI : ST_F_MM;
      end
      ST_F_INI: begin
        cmd.op     = ncs_pkg::OP_INIT;
        init_next  = 1'b0;
        i_next     = '0;
        state_next = ST_F_WR;
      end
      ST_F_MM: begin
        cmd.op     = ncs_pkg::OP_MUL_MU;
        state_next = ST_F_L;
      end
      ST_F_L: begin
        cmd.op     = ncs_pkg::OP_L;
        state_next = ST_F_DM;
      end
      ST_F_DM: begin
        cmd.op     = ncs_pkg::OP_DIV_MU;
        ret_next   = ST_F_MUP;
        state_next = ST_DW;
      end
      ST_F_MUP: begin
        cmd.op     = ncs_pkg::OP_MUP;
        state_next = ST_F_MZ;
      end
      ST_F_MZ: begin
        cmd.op     = ncs_pkg::OP_MUL_Z;
        state_next = ST_F_TZ;
      end
      ST_F_TZ: begin
        cmd.op     = ncs_pkg::OP_TZ;
        state_next = ST_F_DZ;
      end
      ST_F_DZ: begin
        cmd.op     = ncs_pkg::OP_DIV_Z;
        ret_next   = ST_F_ZP;
        state_next = ST_DW;
      end
      ST_F_ZP: begin
        cmd.op     = ncs_pkg::OP_ZP;
        state_next = ST_F_WR;
      end
      ST_F_WR: begin
        cmd.op   = ncs_pkg::OP_WR_MZ;
        cmd.addr = ncs_pkg::ADDR_MAX_W'(i);
        if (i == n_last) begin
          first_next = 1'b1;
          state_next = ST_B_RD;
        end else begin
          i_next     = i + AW'(1);
          state_next = ST_F_RD;
        end
      end
      ST_F_RD: begin
        cmd.addr   = ncs_pkg::ADDR_MAX_W'(i) + ncs_pkg::ADDR_MAX_W'(1);
        state_next = ST_F_SH;
      end
      ST_B_RD: begin
        cmd.addr   = ncs_pkg::ADDR_MAX_W'(i);
        state_next = ST_B_LAT;
      end
      ST_B_LAT: begin
        cmd.op     = first ? ncs_pkg::OP_LATCH_MZ : ncs_pkg::OP_SHIFT_B;
        first_next = 1'b0;
        state_next = ST_B_MC;
      end
      ST_B_MC: begin
        cmd.op     = ncs_pkg::OP_MUL_C;
        state_next = ST_B_C;
      end
      ST_B_C: begin
        cmd.op     = ncs_pkg::OP_C;
        state_next = ST_B_CS;
      end
      ST_B_CS: begin
        cmd.op     = ncs_pkg::OP_CS;
        state_next = ST_B_MH;
      end
      ST_B_MH: begin
        cmd.op     = ncs_pkg::OP_MUL_HC;
        state_next = ST_B_QH;
      end
      ST_B_QH: begin
        cmd.op     = ncs_pkg::OP_QH;
        state_next = ST_B_M3A;
      end
      ST_B_M3A: begin
        cmd.op     = ncs_pkg::OP_M3A;
        state_next = ST_B_D3A;
      end
      ST_B_D3A: begin
        cmd.op     = ncs_pkg::OP_D3A;
        state_next = ST_B_M3B;
      end
      ST_B_M3B: begin
        cmd.op     = ncs_pkg::OP_M3B;
        state_next = ST_B_D3B;
      end
      ST_B_D3B: begin
        cmd.op     = ncs_pkg::OP_D3B;
        state_next = ST_B_DSL;
      end
      ST_B_DSL: begin
        cmd.op     = ncs_pkg::OP_DIV_SL;
        ret_next   = ST_B_B;
        state_next = ST_DW;
      end
      ST_B_B: begin
        cmd.op     = ncs_pkg::OP_B;
        state_next = ST_B_DD;
      end
      ST_B_DD: begin
        cmd.op     = ncs_pkg::OP_DIV_D;
        ret_next   = ST_B_D;
        state_next = ST_DW;
      end
      ST_B_D: begin
        cmd.op     = ncs_pkg::OP_D;
        state_next = ST_B_WR;
      end
      ST_B_WR: begin
        cmd.op   = ncs_pkg::OP_WR_BCD;
        cmd.addr = ncs_pkg::ADDR_MAX_W'(i);
        if (i == '0) begin
          state_next = ST_E_RD;
        end else begin
          i_next     = i - AW'(1);
          state_next = ST_B_RD;
        end
      end
      ST_E_RD: begin
        cmd.addr   = ncs_pkg::ADDR_MAX_W'(i);
        state_next = ST_E_OUT;
      end
      ST_E_OUT: begin
        cmd.op       = ncs_pkg::OP_EMIT;
        cmd.addr     = ncs_pkg::ADDR_MAX_W'(i);
        cmd.last_seg = i == n_last;
        if (i == n_last) begin
          cmd.clr_err = 1'b1;
          cnt_next    = '0;
          state_next  = ST_IDLE;
        end else begin
          i_next     = i + AW'(1);
          state_next = ST_E_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      cnt   <= '0;
      i     <= '0;
      first <= 1'b0;
      init  <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      cnt   <= cnt_next;
      i     <= i_next;
      first <= first_next;
      init  <= init_next;
    end
  end
endmodule

>>> rtl/core/natural_cubic_spline_coefficients.sv
// Top level of the natural cubic spline coefficient solver (Q16.16 default).
// Depends on ncs_pkg, ncs_ctrl, ncs_datapath.
//
//   channel  | handshake              | beat
//   ---------+------------------------+--------------------------------
//   knot in  | start & !busy          | knot_t: knot_x, knot_y, last_knot
//   result   | result_strobe (1 cyc)  | segment_t: coef a..d, start, index
//
// Each knot is written to the knot memory in the cycle it is presented with
// start; busy stays low between knots. After the last knot the solve runs
// with busy high: the divider forms three quotients per interval in the
// forward sweep and two in back substitution (a zero divisor saturates the
// quotient and flags overflow); the segments are then emitted in index order.
// rst is synchronous and clears the controller and the error flag.
// Results cannot be stalled; each beat is shown for exactly one cycle.
module natural_cubic_spline_coefficients #(
  parameter int MAX_KNOTS = ncs_pkg::DEF_MAX_KNOTS,
  parameter int FRAC_BITS = ncs_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ncs_pkg::knot_t    knot,
  output ncs_pkg::segment_t result,
  output logic              result_strobe
);
  ncs_pkg::cmd_t    cmd;
  ncs_pkg::status_t status;

  ncs_ctrl #(.MAX_KNOTS(MAX_KNOTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_knot (knot.last_knot),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  ncs_datapath #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .knot          (knot),
    .status        (status),
    .result        (result),
    .result_strobe (result_strobe)
  );
endmodule
